### rtl/threshold_majority_denoise_assert.svh
// Assertion macros for the threshold majority denoise block.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef THRESHOLD_MAJORITY_DENOISE_ASSERT_SVH
`define THRESHOLD_MAJORITY_DENOISE_ASSERT_SVH
`ifndef SYNTH
`define TMD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TMD_ASSERT(label, prop, msg)
`define TMD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### rtl/tmd_pkg.sv
// Shared types and constants for the threshold majority denoise block.
// No dependencies; every RTL module imports this package.
`default_nettype none
package tmd_pkg;
	localparam int MAX_WIDTH = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int W_SIZE_W = $clog2(MAX_WIDTH + 1);
	localparam int H_SIZE_W = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam int MAJORITY = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_LEVEL_THRESHOLD = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic mode;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic white;
		logic last_of_frame;
	} result_t;

	typedef struct packed {
		logic mode;
		logic level;
	} bin_t;

	typedef struct packed {
		logic [W_SIZE_W-1:0] width;
		logic [H_SIZE_W-1:0] height;
		logic [9:0] white_above;
		logic restart;
	} cfg_t;
endpackage
`default_nettype wire

### rtl/tmd_binarize.sv
// Input register and threshold stage: turns a color request into one level bit.
// Depends on tmd_pkg.
`default_nettype none
module tmd_binarize import tmd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic pixel_valid,
	output logic pixel_stall,
	input wire pixel_t pixel,
	output logic bin_valid,
	input wire logic bin_stall,
	output bin_t bin
);
	logic valid_s1;
	bin_t bin_s1;
	logic [9:0] sum;

	assign sum = {2'b00, pixel.blue} + {2'b00, pixel.green} + {2'b00, pixel.red};
	assign pixel_stall = valid_s1 && bin_stall;
	assign bin_valid = valid_s1;
	assign bin = bin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_valid && !pixel_stall) begin
			valid_s1 <= 1'b1;
		end else if (!bin_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_valid && !pixel_stall) begin
			bin_s1.mode <= pixel.mode;
			bin_s1.level <= sum > cfg.white_above;
		end
	end
endmodule
`default_nettype wire

### rtl/tmd_window.sv
// Row store, 3x3 window, majority vote and result register.
// Depends on tmd_pkg and the assertion macro header.
`default_nettype none
`include "threshold_majority_denoise_assert.svh"
module tmd_window import tmd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic bin_valid,
	output logic bin_stall,
	input wire bin_t bin,
	output logic result_valid,
	input wire logic result_stall,
	output result_t result
);
	logic [1:0] row_mem [MAX_WIDTH];
	logic [1:0] rd_q;
	logic [8:0] window_q, window_d, window_n;
	logic [COL_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [W_SIZE_W-1:0] col_inc;
	logic out_valid_q;
	result_t result_q;
	logic fire, draining, take, level, have, last, wrap, interior, white;

	assign bin_stall = out_valid_q && result_stall;
	assign fire = bin_valid && !bin_stall;
	assign result_valid = out_valid_q;
	assign result = result_q;

	always_comb begin
		draining = row_q >= ROW_W'(cfg.height);
		take = fire && (draining || !bin.mode);
		level = !draining && bin.level;
		window_d = {level, rd_q[0], rd_q[1], window_q[8:3]};
		have = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
		last = (col_q == '0) && (row_q == ROW_W'(cfg.height) + ROW_W'(1));
		col_inc = W_SIZE_W'(col_q) + W_SIZE_W'(1);
		wrap = col_inc >= cfg.width;
		interior = (row_q >= ROW_W'(2)) && (row_q < ROW_W'(cfg.height))
			&& (col_q >= COL_W'(2));
		if (col_q == '0) begin
			white = window_q[7];
		end else if (interior) begin
			white = $countones(window_d) >= MAJORITY;
		end else begin
			white = window_d[4];
		end
		window_n = window_q;
		col_d = col_q;
		row_d = row_q;
		if (cfg.restart || (take && have && last)) begin
			window_n = '0;
			col_d = '0;
			row_d = '0;
		end else if (take) begin
			window_n = window_d;
			if (wrap) begin
				col_d = '0;
				row_d = row_q + ROW_W'(1);
			end else begin
				col_d = col_inc[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			col_q <= '0;
			row_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			window_q <= window_n;
			col_q <= col_d;
			row_q <= row_d;
			if (take && have) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && have) begin
			result_q.white <= white;
			result_q.last_of_frame <= last;
		end
	end

	// The read port always fetches the column of the next request; a one-pixel
	// row rereads the entry written in the same cycle, so it is forwarded.
	always_ff @(posedge clk) begin
		if (take) begin
			row_mem[col_q] <= {rd_q[0], level};
		end
		if (take && col_d == col_q) begin
			rd_q <= {rd_q[0], level};
		end else begin
			rd_q <= row_mem[col_d];
		end
	end

	`TMD_ASSERT(a_col_in_row, W_SIZE_W'(col_q) < cfg.width, "column left the row")
	`TMD_ASSERT(a_row_bound, row_q <= ROW_W'(cfg.height) + ROW_W'(1), "row ran past drain")
	`TMD_ASSERT_NEXT(a_frame_restart, take && have && last,
		row_q == '0 && col_q == '0 && window_q == '0, "frame did not restart")
endmodule
`default_nettype wire

### rtl/threshold_majority_denoise.sv
// Path: a request passes the threshold register, then the result register; the request
// that completes a pixel's window comes frame_width+1 requests after that pixel.
// Throughput: one request per cycle while result_stall is low; the row store read is
// prefetched for the next column so the window can advance every cycle.
// Reset: counters, window and valid flags clear; the row store is not cleared.
// Configuration holds its defaults 640, 480 and 127 after reset.
`default_nettype none
module threshold_majority_denoise import tmd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic pixel_valid,
	output logic pixel_stall,
	input wire pixel_t pixel,
	output logic result_valid,
	input wire logic result_stall,
	output result_t result
);
	logic [11:0] width_q, height_q;
	logic [7:0] threshold_q;
	cfg_t cfg;
	logic bin_valid, bin_stall;
	bin_t bin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 12'd640;
			height_q <= 12'd480;
			threshold_q <= 8'd127;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH: width_q <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				REG_LEVEL_THRESHOLD: threshold_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			cfg.width = W_SIZE_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			cfg.width = W_SIZE_W'(MAX_WIDTH);
		end else begin
			cfg.width = W_SIZE_W'(width_q);
		end
		if (height_q == '0) begin
			cfg.height = H_SIZE_W'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			cfg.height = H_SIZE_W'(MAX_HEIGHT);
		end else begin
			cfg.height = H_SIZE_W'(height_q);
		end
		cfg.white_above = {2'b00, threshold_q} + {1'b0, threshold_q, 1'b0} + 10'd2;
		cfg.restart = cfg_wr_en && (cfg_index == REG_FRAME_WIDTH
			|| cfg_index == REG_FRAME_HEIGHT);
	end

	tmd_binarize u_binarize (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.bin_valid(bin_valid),
		.bin_stall(bin_stall),
		.bin(bin)
	);

	tmd_window u_window (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.bin_valid(bin_valid),
		.bin_stall(bin_stall),
		.bin(bin),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);
endmodule
`default_nettype wire
